FILE: rtl/mmrs_pkg.sv
// ----------------------------------------------------------------------------
// mmrs_pkg
// Shared types and constants for the streaming fixed-point matrix multiplier:
// beat payloads, command codes, register indexes and controller handshake.
// ----------------------------------------------------------------------------
package mmrs_pkg;

    // Default largest matrix dimension
    localparam int DEF_MAX_DIM = 16;

    // Field widths fixed by the interface
    localparam int IDX_W    = 4;
    localparam int VAL_W    = 16;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int SUM_W    = 40;
    localparam int DIM_CFG_W = 5;
    localparam int ROWS_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Input beat command codes
    localparam logic CMD_LOAD_B = 1'b0;
    localparam logic CMD_A_ELEM = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_K = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_N  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [DIM_CFG_W-1:0] RST_INNER_K = 5'd16;
    localparam logic [DIM_CFG_W-1:0] RST_COLS_N  = 5'd16;
    localparam logic [ROWS_W-1:0]    RST_ROWS_M  = 16'd1;

    // Input beat
    typedef struct packed {
        logic                    cmd;
        logic [IDX_W-1:0]        inner_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic [IDX_W-1:0]        out_column;
        logic signed [SUM_W-1:0] dot_sum;
        logic                    row_last;
        logic                    matrix_last;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load_b;       // write the input beat into the B store
        logic load_a;       // capture the A element and its inner index
        logic issue;        // read one B entry into the MAC pipe
        logic emit;         // move one accumulator to the output register
        logic row_last;     // emitted result closes its row
        logic matrix_last;  // emitted result closes the matrix
    } t_mmrs_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_busy;    // MAC pipe still holds products in flight
        logic out_free;     // output register can take a result this cycle
    } t_mmrs_stat;

endpackage

FILE: rtl/mmrs_datapath.sv
// ----------------------------------------------------------------------------
// mmrs_datapath
// B store, shared multiply-accumulate pipe, column accumulators and the
// result output register.
// ----------------------------------------------------------------------------
module mmrs_datapath
    import mmrs_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_in_item                   i_in_data,
    input  t_mmrs_cmd                  i_cmd,
    input  logic [$clog2(MAX_DIM)-1:0] i_col,
    output t_mmrs_stat                 o_stat,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output t_out_item                  o_out_data
);

    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    logic [VAL_W-1:0]        r_b_mem [MEM_DEPTH];
    logic signed [VAL_W-1:0] r_a_val;
    logic [IDX_W-1:0]        r_a_ki;
    logic signed [VAL_W-1:0] r_rd_data;
    logic                    r_s1_valid;
    logic [DIM_W-1:0]        r_s1_col;
    logic signed [PROD_W-1:0] r_prod;
    logic                    r_s2_valid;
    logic [DIM_W-1:0]        r_s2_col;
    logic signed [SUM_W-1:0] r_acc [MAX_DIM];
    logic                    r_out_valid;
    t_out_item               r_out_data;

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // Row-major store address: inner index selects the row
    assign wr_addr = ADDR_W'(ADDR_W'(i_in_data.inner_index) * ADDR_W'(MAX_DIM))
                     + ADDR_W'(i_in_data.col_index);
    assign rd_addr = ADDR_W'(ADDR_W'(r_a_ki) * ADDR_W'(MAX_DIM)) + ADDR_W'(i_col);

    // B store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_b) begin
            r_b_mem[wr_addr] <= i_in_data.value;
        end
        if (i_cmd.issue) begin
            r_rd_data <= $signed(r_b_mem[rd_addr]);
        end
    end

    // Capture the A element for the column sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) begin
            r_a_val <= i_in_data.value;
            r_a_ki  <= i_in_data.inner_index;
        end
    end

    // Advance the MAC pipe: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col <= i_col;
        r_s2_col <= r_s1_col;
        r_prod   <= r_a_val * r_rd_data;
    end

    // Accumulate products; clear each column as it is emitted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DIM; i++) begin
                r_acc[i] <= '0;
            end
        end else if (r_s2_valid) begin
            r_acc[r_s2_col] <= r_acc[r_s2_col]
                               + {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end else if (i_cmd.emit) begin
            r_acc[i_col] <= '0;
        end
    end

    // Output register: load on emit, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.out_column  <= IDX_W'(i_col);
            r_out_data.dot_sum     <= r_acc[i_col];
            r_out_data.row_last    <= i_cmd.row_last;
            r_out_data.matrix_last <= i_cmd.matrix_last;
        end
    end

    assign o_stat.pipe_busy = r_s1_valid | r_s2_valid;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out_data;

endmodule

FILE: rtl/mmrs_ctrl.sv
// ----------------------------------------------------------------------------
// mmrs_ctrl
// Configuration registers, row counter and the sequencer that sweeps the
// columns for each A element and emits a finished row.
// ----------------------------------------------------------------------------
module mmrs_ctrl
    import mmrs_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  t_in_item                   i_in_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  t_mmrs_stat                 i_stat,
    output t_mmrs_cmd                  o_cmd,
    output logic [$clog2(MAX_DIM)-1:0] o_col
);

    localparam int DIM_W = $clog2(MAX_DIM);
    localparam int CNT_W = $clog2(MAX_DIM + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [DIM_W-1:0]      r_col, n_col;
    logic                  r_last, n_last;
    logic [ROWS_W-1:0]     r_row, n_row;
    logic [DIM_CFG_W-1:0]  r_inner_k;
    logic [DIM_CFG_W-1:0]  r_cols_n;
    logic [ROWS_W-1:0]     r_rows_m;

    logic [CNT_W-1:0]  k_eff;
    logic [CNT_W-1:0]  n_eff;
    logic [ROWS_W-1:0] m_eff;
    logic              last_row;
    logic              col_end;
    logic              in_acc;
    logic              ki_ok;
    logic              ci_ok;

    // Configuration write channel is always open
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_k <= RST_INNER_K;
            r_cols_n  <= RST_COLS_N;
            r_rows_m  <= RST_ROWS_M;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INNER_K: r_inner_k <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_COLS_N:  r_cols_n  <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_ROWS_M:  r_rows_m  <= i_cfg_data[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp inner and column sizes to 1..MAX_DIM; zero rows act as one
    always_comb begin
        if (r_inner_k == '0) begin
            k_eff = CNT_W'(1);
        end else if (32'(r_inner_k) > MAX_DIM) begin
            k_eff = CNT_W'(MAX_DIM);
        end else begin
            k_eff = CNT_W'(r_inner_k);
        end
        if (r_cols_n == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(r_cols_n) > MAX_DIM) begin
            n_eff = CNT_W'(MAX_DIM);
        end else begin
            n_eff = CNT_W'(r_cols_n);
        end
        m_eff = (r_rows_m == '0) ? ROWS_W'(1) : r_rows_m;
    end

    assign in_acc   = i_in_valid && o_in_ready;
    assign ki_ok    = 32'(i_in_data.inner_index) < 32'(k_eff);
    assign ci_ok    = 32'(i_in_data.col_index) < 32'(n_eff);
    assign col_end  = 32'(r_col) == 32'(n_eff) - 1;
    assign last_row = ({1'b0, r_row} + (ROWS_W+1)'(1)) >= {1'b0, m_eff};

    // Sequence: accept, sweep columns, drain, emit when a row closes
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_last  = r_last;
        n_row   = r_row;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.cmd == CMD_A_ELEM) begin
                        if (ki_ok) begin
                            o_cmd.load_a = 1'b1;
                            n_last  = 32'(i_in_data.inner_index) == 32'(k_eff) - 1;
                            n_col   = '0;
                            n_state = ST_MAC;
                        end
                    end else begin
                        o_cmd.load_b = ki_ok && ci_ok;
                    end
                end
            end
            ST_MAC: begin
                o_cmd.issue = 1'b1;
                if (col_end) begin
                    n_col   = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_col = r_col + DIM_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.row_last    = col_end;
                    o_cmd.matrix_last = col_end && last_row;
                    if (col_end) begin
                        n_col   = '0;
                        n_row   = last_row ? '0 : r_row + ROWS_W'(1);
                        n_state = ST_IDLE;
                    end else begin
                        n_col = r_col + DIM_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_last  <= 1'b0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_last  <= n_last;
            r_row   <= n_row;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_col      = r_col;

endmodule

FILE: rtl/matrix_multiply_row_stream_top.sv
// ----------------------------------------------------------------------------
// matrix_multiply_row_stream_top
// Streaming fixed-point C = A x B: B loaded entry by entry, A streamed by rows.
// ----------------------------------------------------------------------------
// A B-load beat is written into the B store when accepted and its indexes are
// in range. An A element is accepted, then the sequencer issues one B store
// read per clamped column through the single read port, feeding one shared
// multiplier and adder, and waits until the read and product registers of that
// pipe are empty. The element that closes a row then emits one result beat per
// column, held while the output side stalls. Accumulators clear at reset
// directly; the B store has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module matrix_multiply_row_stream_top
    import mmrs_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_mmrs_cmd                  cmd;
    t_mmrs_stat                 stat;
    logic [$clog2(MAX_DIM)-1:0] col;

    // Sequencer and configuration
    mmrs_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_col       (col)
    );

    // Store, MAC pipe and result register
    mmrs_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_col       (col),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/mmrs_checker.sv
// ----------------------------------------------------------------------------
// mmrs_checker
// Port-level checks on the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module mmrs_checker
    import mmrs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_data
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // Matrix end only on a row end
    a_last_nest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.matrix_last |-> o_out_data.row_last)
        else $error("matrix_last without row_last");

    // No new input while a row is still being emitted
    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.row_last |-> !o_in_ready)
        else $error("input accepted in the middle of a row");

    // Drop the output after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind matrix_multiply_row_stream_top mmrs_checker u_mmrs_checker (.*);
